@@ rtl/jsu_pkg.sv @@
// jsu_pkg: types, codes and helper functions for the json string unescaper
// used by json_string_unescape_validate_core; no dependencies
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_ESC,
    PH_HEX,
    PH_WANT_BS,
    PH_WANT_U,
    PH_HEX_LOW
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_NO_OPEN      = 4'd1,
    ERR_TOO_LONG     = 4'd2,
    ERR_BAD_UTF8     = 4'd3,
    ERR_CONTROL      = 4'd4,
    ERR_BAD_ESCAPE   = 4'd5,
    ERR_BAD_UNICODE  = 4'd6,
    ERR_SURROGATE    = 4'd7,
    ERR_UNTERMINATED = 4'd8
  } err_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [15:0] MAX_RESET = 16'd4096;

  typedef struct packed {
    logic [1:0]  pending;
    logic [20:0] cp;
    logic [1:0]  min_class;
    logic        bad;
  } utf8_st_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } enc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) h.val = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) h.val = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) h.val = 4'(c - 8'h37);
    else h.ok = 1'b0;
    return h;
  endfunction

  // one byte into the incremental utf-8 checker
  function automatic utf8_st_t utf8_feed(input utf8_st_t s, input logic [7:0] b);
    utf8_st_t    r;
    logic [20:0] lo;
    r = s;
    if (!s.bad) begin
      if (s.pending == 2'd0) begin
        if (b[7]) begin
          if ((b & 8'hE0) == 8'hC0) begin
            r.pending = 2'd1; r.cp = {16'd0, b[4:0]}; r.min_class = 2'd1;
          end else if ((b & 8'hF0) == 8'hE0) begin
            r.pending = 2'd2; r.cp = {17'd0, b[3:0]}; r.min_class = 2'd2;
          end else if ((b & 8'hF8) == 8'hF0) begin
            r.pending = 2'd3; r.cp = {18'd0, b[2:0]}; r.min_class = 2'd3;
          end else begin
            r.bad = 1'b1;
          end
        end
      end else if ((b & 8'hC0) != 8'h80) begin
        r.bad = 1'b1;
      end else begin
        r.cp      = {s.cp[14:0], b[5:0]};
        r.pending = s.pending - 2'd1;
        if (r.pending == 2'd0) begin
          lo = (s.min_class == 2'd1) ? 21'h80 :
               ((s.min_class == 2'd2) ? 21'h800 : 21'h10000);
          if (r.cp < lo || r.cp > 21'h10FFFF || (r.cp >= 21'hD800 && r.cp <= 21'hDFFF))
            r.bad = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // utf-8 encoding of a code point up to 0x10ffff, first byte in b[0]
  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e.b = '0;
    if (cp <= 21'h7F) begin
      e.n = 3'd1; e.b[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      e.n = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.n = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.n = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

@@ rtl/json_string_unescape_validate_core.sv @@
// json_string_unescape_validate_core: json string unescaper with utf-8 output and check
// depends on jsu_pkg
//
// Usage: source bytes of one json string enter on the in_ channel (valid/stall),
// starting with the opening quote. Each transaction carries in_byte and
// in_end_of_source. Decoded utf-8 bytes, then one done or error status, leave on
// the out_ channel (valid/stall); out_last marks the final result of an input
// transaction. Steps that only consume (opening quote, backslash, hex digits before the last) give none.
// Results of a transaction are registered and valid the cycle after it is accepted.
// One transaction per cycle while each gives at most one result and out_stall is low;
// a \u escape that decodes to n bytes holds the input while the result buffer drains,
// one byte per cycle while out_stall is low.
// The cfg_ channel (valid/ready, always ready) writes max_string_bytes; write it
// only while idle. Reset (synchronous, rst_n low) sets the limit to 4096, empties
// the result buffer and waits for an opening quote. While out_stall is high the
// shown result holds and input is stalled once no result slot would free up.
module json_string_unescape_validate_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [3:0]  out_error_code,
  output logic [16:0] out_decoded_length,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_string_bytes
);
  import jsu_pkg::*;

  logic [15:0]     max_r;
  phase_t          phase_r, phase_nxt;
  logic [1:0]      hcnt_r, hcnt_nxt;
  logic [15:0]     hacc_r, hacc_nxt;
  logic [9:0]      hsur_r, hsur_nxt;
  logic [16:0]     count_r, count_nxt;
  utf8_st_t        u8_r, u8_nxt;

  logic [2:0]      cnt_r, cnt_nxt;
  kind_t           kind_r, kind_nxt;
  err_t            err_r, err_nxt;
  logic [16:0]     len_r, len_nxt;
  logic [3:0][7:0] buf_r, buf_nxt;

  logic            pop, in_acc;
  logic            do_fail, do_done, emit_en, emit_cp;
  err_t            fail_code;
  enc_t            emit;
  hex_t            hv;
  logic [15:0]     acc_new;
  logic [17:0]     count_sum;

  assign cfg_ready = 1'b1;
  assign pop       = (cnt_r != 3'd0) && !out_stall;
  assign in_stall  = !((cnt_r == 3'd0) || (cnt_r == 3'd1 && !out_stall));
  assign in_acc    = in_valid && !in_stall;

  assign out_valid          = cnt_r != 3'd0;
  assign out_kind           = kind_r;
  assign out_data_byte      = buf_r[0];
  assign out_error_code     = err_r;
  assign out_decoded_length = len_r;
  assign out_last           = cnt_r == 3'd1;

  assign hv      = hex_value(in_byte);
  assign acc_new = {hacc_r[11:0], hv.val};

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    hacc_nxt  = hacc_r;
    hsur_nxt  = hsur_r;
    count_nxt = count_r;
    u8_nxt    = u8_r;
    do_fail   = 1'b0;
    do_done   = 1'b0;
    fail_code = ERR_NONE;
    emit_en   = 1'b0;
    emit_cp   = 1'b0;
    emit      = '0;
    count_sum = '0;

    unique case (phase_r)
      PH_BODY: begin
        if (in_end_of_source) begin
          do_fail = 1'b1; fail_code = ERR_UNTERMINATED;
        end else if (in_byte == CH_QUOTE) begin
          if (count_r > {1'b0, max_r}) begin
            do_fail = 1'b1; fail_code = ERR_TOO_LONG;
          end else if (u8_r.bad || u8_r.pending != 2'd0) begin
            do_fail = 1'b1; fail_code = ERR_BAD_UTF8;
          end else begin
            do_done = 1'b1;
          end
        end else if (in_byte < CH_SPACE) begin
          do_fail = 1'b1; fail_code = ERR_CONTROL;
        end else if (in_byte == CH_BSL) begin
          phase_nxt = PH_ESC;
        end else begin
          emit_en = 1'b1; emit.n = 3'd1; emit.b[0] = in_byte;
        end
      end
      PH_ESC: begin
        phase_nxt = PH_BODY;
        emit.n    = 3'd1;
        if (in_end_of_source) begin
          do_fail = 1'b1; fail_code = ERR_BAD_ESCAPE;
        end else begin
          unique case (in_byte)
            CH_QUOTE, CH_BSL, CH_SLASH: begin emit_en = 1'b1; emit.b[0] = in_byte; end
            CH_B: begin emit_en = 1'b1; emit.b[0] = 8'h08; end
            CH_F: begin emit_en = 1'b1; emit.b[0] = 8'h0C; end
            CH_N: begin emit_en = 1'b1; emit.b[0] = 8'h0A; end
            CH_R: begin emit_en = 1'b1; emit.b[0] = 8'h0D; end
            CH_T: begin emit_en = 1'b1; emit.b[0] = 8'h09; end
            CH_U: begin phase_nxt = PH_HEX; hcnt_nxt = 2'd0; hacc_nxt = 16'd0; end
            default: begin do_fail = 1'b1; fail_code = ERR_BAD_ESCAPE; end
          endcase
        end
      end
      PH_HEX, PH_HEX_LOW: begin
        if (in_end_of_source || !hv.ok) begin
          do_fail = 1'b1; fail_code = ERR_BAD_UNICODE;
        end else begin
          hacc_nxt = acc_new;
          if (hcnt_r != 2'd3) begin
            hcnt_nxt = hcnt_r + 2'd1;
          end else begin
            hcnt_nxt = 2'd0;
            if (phase_r == PH_HEX) begin
              if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                hsur_nxt  = acc_new[9:0];
                phase_nxt = PH_WANT_BS;
              end else if (acc_new >= 16'hDC00) begin
                if (acc_new <= 16'hDFFF) begin
                  do_fail = 1'b1; fail_code = ERR_SURROGATE;
                end else begin
                  phase_nxt = PH_BODY; emit_en = 1'b1; emit_cp = 1'b1;
                  emit = utf8_encode({5'd0, acc_new});
                end
              end else begin
                phase_nxt = PH_BODY; emit_en = 1'b1; emit_cp = 1'b1;
                emit = utf8_encode({5'd0, acc_new});
              end
            end else if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
              do_fail = 1'b1; fail_code = ERR_SURROGATE;
            end else begin
              phase_nxt = PH_BODY; emit_en = 1'b1; emit_cp = 1'b1;
              emit = utf8_encode(21'h10000 + {1'b0, hsur_r, acc_new[9:0]});
            end
          end
        end
      end
      PH_WANT_BS: begin
        if (in_end_of_source || in_byte != CH_BSL) begin
          do_fail = 1'b1; fail_code = ERR_SURROGATE;
        end else begin
          phase_nxt = PH_WANT_U;
        end
      end
      PH_WANT_U: begin
        if (in_end_of_source || in_byte != CH_U) begin
          do_fail = 1'b1; fail_code = ERR_SURROGATE;
        end else begin
          phase_nxt = PH_HEX_LOW; hcnt_nxt = 2'd0; hacc_nxt = 16'd0;
        end
      end
      default: begin
        if (!in_end_of_source && in_byte == CH_QUOTE) begin
          phase_nxt = PH_BODY;
        end else begin
          do_fail = 1'b1; fail_code = ERR_NO_OPEN;
        end
      end
    endcase

    if (emit_en) begin
      count_sum = {1'b0, count_r} + {15'd0, emit.n};
      if (count_sum > {2'b00, max_r}) begin
        do_fail = 1'b1; fail_code = ERR_TOO_LONG;
      end else begin
        count_nxt = count_sum[16:0];
        // a whole encoded code point keeps a clean checker clean,
        // and breaks any sequence still open
        if (emit_cp) begin
          if (u8_r.pending != 2'd0) u8_nxt.bad = 1'b1;
        end else begin
          u8_nxt = utf8_feed(u8_r, emit.b[0]);
        end
      end
    end

    if (do_fail || do_done) begin
      phase_nxt = PH_IDLE;
      hcnt_nxt  = 2'd0;
      hacc_nxt  = 16'd0;
      hsur_nxt  = 10'd0;
      count_nxt = 17'd0;
      u8_nxt    = '0;
    end
  end

  // result buffer: loads on an accepted transaction, drains one byte per pop
  always_comb begin
    cnt_nxt  = cnt_r;
    kind_nxt = kind_r;
    err_nxt  = err_r;
    len_nxt  = len_r;
    buf_nxt  = buf_r;
    if (pop) begin
      cnt_nxt = cnt_r - 3'd1;
      buf_nxt = {8'h00, buf_r[3:1]};
    end
    if (in_acc) begin
      if (do_fail) begin
        cnt_nxt = 3'd1; kind_nxt = KIND_ERR; err_nxt = fail_code;
        len_nxt = 17'd0; buf_nxt = '0;
      end else if (do_done) begin
        cnt_nxt = 3'd1; kind_nxt = KIND_DONE; err_nxt = ERR_NONE;
        len_nxt = count_r; buf_nxt = '0;
      end else if (emit_en) begin
        cnt_nxt = emit.n; kind_nxt = KIND_DATA; err_nxt = ERR_NONE;
        len_nxt = 17'd0; buf_nxt = emit.b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= MAX_RESET;
      phase_r <= PH_IDLE;
      hcnt_r  <= 2'd0;
      hacc_r  <= 16'd0;
      hsur_r  <= 10'd0;
      count_r <= 17'd0;
      u8_r    <= '0;
      cnt_r   <= 3'd0;
      kind_r  <= KIND_DATA;
      err_r   <= ERR_NONE;
    end else begin
      if (cfg_valid && cfg_ready) max_r <= cfg_max_string_bytes;
      if (in_acc) begin
        phase_r <= phase_nxt;
        hcnt_r  <= hcnt_nxt;
        hacc_r  <= hacc_nxt;
        hsur_r  <= hsur_nxt;
        count_r <= count_nxt;
        u8_r    <= u8_nxt;
      end
      cnt_r  <= cnt_nxt;
      kind_r <= kind_nxt;
      err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    buf_r <= buf_nxt;
  end

`ifndef SYNTHESIS
  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DATA) |-> out_last)
    else $error("status result is not the last of its transaction");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (count_r == 17'd0 && !u8_r.bad && u8_r.pending == 2'd0))
    else $error("string state not cleared while waiting for a quote");

  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_DATA) |-> (out_error_code == ERR_NONE
      && out_decoded_length == 17'd0))
    else $error("data result carries status fields");

  a_burst_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > 3'd1 && !out_stall) |=> (cnt_r == $past(cnt_r) - 3'd1))
    else $error("result burst did not drain by one");
`endif

endmodule

@@ test/jsu_tb_pkg.sv @@
// jsu_tb_pkg: result record, utf-8 encoder and the scoreboard class that predicts
// and checks the json string unescaper; depends on jsu_pkg
`timescale 1ns / 100ps
package jsu_tb_pkg;
  import jsu_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    err_t        err;
    logic [16:0] len;
    logic        last;
  } result_t;

  // utf-8 bytes of a code point, first byte in b[0]; returns the byte count
  function automatic int to_utf8(input logic [20:0] cp, output logic [3:0][7:0] b);
    b = '0;
    if (cp < 21'h80) begin
      b[0] = cp[7:0];
      return 1;
    end
    if (cp < 21'h800) begin
      b[0] = {3'b110, cp[10:6]};
      b[1] = {2'b10, cp[5:0]};
      return 2;
    end
    if (cp < 21'h10000) begin
      b[0] = {4'b1110, cp[15:12]};
      b[1] = {2'b10, cp[11:6]};
      b[2] = {2'b10, cp[5:0]};
      return 3;
    end
    b[0] = {5'b11110, cp[20:18]};
    b[1] = {2'b10, cp[17:12]};
    b[2] = {2'b10, cp[11:6]};
    b[3] = {2'b10, cp[5:0]};
    return 4;
  endfunction

  class unescape_checker;
    phase_t      ph;
    int unsigned hex_cnt;
    logic [15:0] hex_acc;
    logic [9:0]  high_bits;
    int unsigned count;
    int unsigned seq_left;
    logic [20:0] seq_cp;
    int unsigned seq_class;
    bit          seq_bad;
    logic [15:0] max_bytes;
    result_t     expected_out[$];
    result_t     step_out[$];
    int unsigned mismatches;
    int unsigned n_data;
    int unsigned n_done;
    int unsigned n_err;
    bit          err_seen[16];

    function new();
      max_bytes = MAX_RESET;
      restart();
    endfunction

    function void restart();
      ph        = PH_IDLE;
      hex_cnt   = 0;
      hex_acc   = '0;
      high_bits = '0;
      count     = 0;
      seq_left  = 0;
      seq_cp    = '0;
      seq_class = 0;
      seq_bad   = 1'b0;
    endfunction

    function void set_limit(logic [15:0] v);
      max_bytes = v;
    endfunction

    function bit drained();
      return expected_out.size() == 0;
    endfunction

    function void push(kind_t k, logic [7:0] d, err_t e, logic [16:0] l);
      result_t r;
      r.kind = k;
      r.data = d;
      r.err  = e;
      r.len  = l;
      r.last = 1'b0;
      step_out.insert(step_out.size(), r);
    endfunction

    function void reject(err_t e);
      push(KIND_ERR, 8'd0, e, 17'd0);
      restart();
    endfunction

    // incremental well-formedness check of the decoded byte stream
    function void track_utf8(logic [7:0] b);
      logic [20:0] floor_cp;
      if (seq_bad) return;
      if (seq_left == 0) begin
        if (!b[7]) return;
        if (b[7:5] == 3'b110) begin
          seq_left = 1; seq_cp = {16'd0, b[4:0]}; seq_class = 1;
        end else if (b[7:4] == 4'b1110) begin
          seq_left = 2; seq_cp = {17'd0, b[3:0]}; seq_class = 2;
        end else if (b[7:3] == 5'b11110) begin
          seq_left = 3; seq_cp = {18'd0, b[2:0]}; seq_class = 3;
        end else begin
          seq_bad = 1'b1;
        end
        return;
      end
      if (b[7:6] != 2'b10) begin
        seq_bad = 1'b1;
        return;
      end
      seq_cp = {seq_cp[14:0], b[5:0]};
      seq_left--;
      if (seq_left == 0) begin
        floor_cp = (seq_class == 1) ? 21'h80 : ((seq_class == 2) ? 21'h800 : 21'h10000);
        if (seq_cp < floor_cp || seq_cp > 21'h10FFFF ||
            (seq_cp >= 21'hD800 && seq_cp <= 21'hDFFF))
          seq_bad = 1'b1;
      end
    endfunction

    // all bytes of one step go out, or none of them and the length error
    function void emit_bytes(logic [3:0][7:0] b, int n);
      if (count + n > max_bytes) begin
        reject(ERR_TOO_LONG);
        return;
      end
      for (int i = 0; i < n; i++) begin
        push(KIND_DATA, b[i], ERR_NONE, 17'd0);
        track_utf8(b[i]);
        count++;
      end
    endfunction

    function void emit_code_point(logic [20:0] cp);
      logic [3:0][7:0] b;
      int              n;
      n = to_utf8(cp, b);
      emit_bytes(b, n);
    endfunction

    function int hex_nibble(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
      return -1;
    endfunction

    // one accepted source transaction; its expected results join the queue
    function void take_source_byte(logic [7:0] c, bit eos);
      int          d;
      logic [20:0] cp;
      step_out.delete();
      case (ph)
        PH_BODY: begin
          if (eos) reject(ERR_UNTERMINATED);
          else if (c == CH_QUOTE) begin
            if (count > max_bytes) reject(ERR_TOO_LONG);
            else if (seq_bad || seq_left != 0) reject(ERR_BAD_UTF8);
            else begin
              push(KIND_DONE, 8'd0, ERR_NONE, 17'(count));
              restart();
            end
          end else if (c < CH_SPACE) reject(ERR_CONTROL);
          else if (c == CH_BSL) ph = PH_ESC;
          else emit_bytes({24'd0, c}, 1);
        end
        PH_ESC: begin
          if (eos) reject(ERR_BAD_ESCAPE);
          else begin
            ph = PH_BODY;
            case (c)
              CH_QUOTE, CH_BSL, CH_SLASH: emit_bytes({24'd0, c}, 1);
              CH_B: emit_bytes({24'd0, 8'h08}, 1);
              CH_F: emit_bytes({24'd0, 8'h0C}, 1);
              CH_N: emit_bytes({24'd0, 8'h0A}, 1);
              CH_R: emit_bytes({24'd0, 8'h0D}, 1);
              CH_T: emit_bytes({24'd0, 8'h09}, 1);
              CH_U: begin
                ph      = PH_HEX;
                hex_cnt = 0;
                hex_acc = '0;
              end
              default: reject(ERR_BAD_ESCAPE);
            endcase
          end
        end
        PH_HEX, PH_HEX_LOW: begin
          d = eos ? -1 : hex_nibble(c);
          if (d < 0) reject(ERR_BAD_UNICODE);
          else begin
            hex_acc = {hex_acc[11:0], 4'(d)};
            if (hex_cnt < 3) hex_cnt++;
            else begin
              hex_cnt = 0;
              if (ph == PH_HEX) begin
                if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                  high_bits = hex_acc[9:0];
                  ph        = PH_WANT_BS;
                end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                  reject(ERR_SURROGATE);
                end else begin
                  ph = PH_BODY;
                  emit_code_point({5'd0, hex_acc});
                end
              end else if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
                reject(ERR_SURROGATE);
              end else begin
                cp = 21'h10000 + {high_bits, hex_acc[9:0]};
                ph = PH_BODY;
                emit_code_point(cp);
              end
            end
          end
        end
        PH_WANT_BS: begin
          if (eos || c != CH_BSL) reject(ERR_SURROGATE);
          else ph = PH_WANT_U;
        end
        PH_WANT_U: begin
          if (eos || c != CH_U) reject(ERR_SURROGATE);
          else begin
            ph      = PH_HEX_LOW;
            hex_cnt = 0;
            hex_acc = '0;
          end
        end
        default: begin
          if (!eos && c == CH_QUOTE) begin
            restart();
            ph = PH_BODY;
          end else reject(ERR_NO_OPEN);
        end
      endcase
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) expected_out.insert(expected_out.size(), step_out[i]);
    endfunction

    function void compare(string field, logic [16:0] want, logic [16:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic [3:0] err,
                               logic [16:0] len, logic last);
      result_t w;
      if (expected_out.size() == 0) begin
        $error("unexpected result: kind %0d data %0d error %0d length %0d",
               kind, data, err, len);
        mismatches++;
        return;
      end
      w = expected_out.pop_front();
      compare("kind", w.kind, kind);
      compare("data_byte", w.data, data);
      compare("error_code", w.err, err);
      compare("decoded_length", w.len, len);
      compare("last", w.last, last);
      case (w.kind)
        KIND_DATA: n_data++;
        KIND_DONE: n_done++;
        default: begin
          n_err++;
          err_seen[w.err] = 1'b1;
        end
      endcase
    endfunction

    function void summarize(int unsigned bytes_sent);
      int unsigned codes;
      codes = 0;
      foreach (err_seen[i]) if (err_seen[i]) codes++;
      $display("covered %0d source bytes and %0d results: %0d data bytes, %0d strings, %0d errors",
               bytes_sent, n_data + n_done + n_err, n_data, n_done, n_err);
      $display("%0d of 8 error kinds hit, length limits 0 to 65535, four idle and stall mixes",
               codes);
    endfunction
  endclass

endpackage

@@ test/json_string_unescape_validate_core_tb.sv @@
// json_string_unescape_validate_core_tb: directed and random json strings against the
// unescaper core, checked by the scoreboard; depends on jsu_pkg and jsu_tb_pkg
`timescale 1ns / 100ps
module json_string_unescape_validate_core_tb;
  import jsu_pkg::*;
  import jsu_tb_pkg::*;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int ITEMS_PER_PHASE = 6;

  typedef logic [7:0] src_q_t[$];

  logic        clk                  = 1'b0;
  logic        rst_n                = 1'b0;
  logic        in_valid             = 1'b0;
  logic [7:0]  in_byte              = 8'd0;
  logic        in_end_of_source     = 1'b0;
  logic        out_stall            = 1'b0;
  logic        cfg_valid            = 1'b0;
  logic [15:0] cfg_max_string_bytes = MAX_RESET;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [3:0]  out_error_code;
  logic [16:0] out_decoded_length;
  logic        out_last;
  logic        cfg_ready;

  unescape_checker chk = new();
  int unsigned     gap_pct     = 0;
  int unsigned     stall_pct   = 0;
  int unsigned     sent_bytes  = 0;
  int unsigned     idle_cycles = 0;

  json_string_unescape_validate_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte             (in_byte),
    .in_end_of_source    (in_end_of_source),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_data_byte       (out_data_byte),
    .out_error_code      (out_error_code),
    .out_decoded_length  (out_decoded_length),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_max_string_bytes(cfg_max_string_bytes)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      chk.check_result(out_kind, out_data_byte, out_error_code, out_decoded_length, out_last);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // adds one source byte at the end of a queue
  function automatic void append(ref src_q_t q, input logic [7:0] c);
    q.insert(q.size(), c);
  endfunction

  task automatic send_item(input logic [7:0] c, input bit eos);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_byte          <= c;
    in_end_of_source <= eos;
    do @(posedge clk); while (in_stall);
    chk.take_source_byte(c, eos);
    sent_bytes++;
  endtask

  // stops early once the string is closed or rejected
  task automatic send_bytes(input src_q_t q);
    foreach (q[i]) begin
      send_item(q[i], 1'b0);
      if (chk.ph == PH_IDLE) break;
    end
  endtask

  task automatic send_text(input string s);
    src_q_t q;
    for (int i = 0; i < s.len(); i++) append(q, s[i]);
    send_bytes(q);
  endtask

  // end of source while a string is open
  task automatic cut_source();
    if (chk.ph != PH_IDLE) send_item(8'($urandom), 1'b1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (!chk.drained()) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_valid            <= 1'b1;
    cfg_max_string_bytes <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    chk.set_limit(v);
    @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  function automatic void push_u(ref src_q_t q, input logic [15:0] v);
    append(q, CH_BSL);
    append(q, CH_U);
    for (int i = 3; i >= 0; i--) append(q, hex_char(v[4*i +: 4]));
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h7E, 8'h20)); while (c == CH_QUOTE || c == CH_BSL);
    return c;
  endfunction

  function automatic logic [15:0] high_half();
    return 16'hD800 | 16'($urandom_range(10'h3FF));
  endfunction

  function automatic void push_element(ref src_q_t q);
    logic [7:0]      esc_letters [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    logic [3:0][7:0] enc;
    logic [20:0]     cp;
    logic [15:0]     v;
    int              n;
    int              r;
    r = $urandom_range(99);
    if (r < 40) append(q, plain_char());
    else if (r < 55) begin
      append(q, CH_BSL);
      append(q, esc_letters[$urandom_range(7)]);
    end else if (r < 68) begin
      v = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(16'h7FF));
      if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
      push_u(q, v);
    end else if (r < 76) begin
      push_u(q, high_half());
      push_u(q, 16'hDC00 | 16'($urandom_range(10'h3FF)));
    end else if (r < 94) begin
      // raw multi-byte utf-8 in the source
      case ($urandom_range(2))
        0: cp = 21'($urandom_range(21'h7FF, 21'h80));
        1: do cp = 21'($urandom_range(21'hFFFF, 21'h800));
           while (cp >= 21'hD800 && cp <= 21'hDFFF);
        default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
      endcase
      n = to_utf8(cp, enc);
      for (int i = 0; i < n; i++) append(q, enc[i]);
    end else begin
      append(q, 8'($urandom_range(255, 128)));
    end
  endfunction

  function automatic void push_fault(ref src_q_t q);
    logic [7:0]  not_hex [6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
    logic [7:0]  c;
    logic [15:0] v;
    case ($urandom_range(7))
      0: append(q, 8'($urandom_range(8'h1F)));
      1: begin
        do c = 8'($urandom);
        while (c inside {CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
        append(q, CH_BSL);
        append(q, c);
      end
      2: begin
        append(q, CH_BSL);
        append(q, CH_U);
        repeat ($urandom_range(3)) append(q, hex_char(4'($urandom)));
        append(q, not_hex[$urandom_range(5)]);
      end
      3: push_u(q, 16'hDC00 | 16'($urandom_range(10'h3FF)));
      4: begin
        push_u(q, high_half());
        append(q, plain_char());
      end
      5: begin
        push_u(q, high_half());
        append(q, CH_BSL);
        append(q, CH_N);
      end
      6: begin
        v = 16'($urandom);
        if (v >= 16'hDC00 && v <= 16'hDFFF) v = v ^ 16'h2000;
        push_u(q, high_half());
        push_u(q, v);
      end
      default: begin
        push_u(q, high_half());
        append(q, CH_BSL);
        append(q, CH_U);
        append(q, not_hex[$urandom_range(5)]);
      end
    endcase
  endfunction

  // mostly well-formed strings, a quarter with one fault somewhere in the body
  task automatic send_random_string();
    src_q_t q;
    int     n_elem;
    int     fault_at;
    int     ending;
    append(q, CH_QUOTE);
    n_elem   = $urandom_range(10);
    fault_at = -1;
    if ($urandom_range(3) == 0) fault_at = $urandom_range(n_elem);
    for (int i = 0; i < n_elem; i++) begin
      if (i == fault_at) push_fault(q);
      push_element(q);
    end
    if (fault_at == n_elem) push_fault(q);
    ending = $urandom_range(19);
    if (ending > 1) append(q, CH_QUOTE);
    send_bytes(q);
    if (ending == 1) cut_source();
  endtask

  task automatic send_noise();
    logic [7:0] c;
    repeat ($urandom_range(3, 1)) begin
      if ($urandom_range(3) == 0) send_item(8'($urandom), 1'b1);
      else begin
        do c = 8'($urandom); while (c == CH_QUOTE);
        send_item(c, 1'b0);
      end
    end
  endtask

  task automatic run_random_phase(input int unsigned gap, input int unsigned stall,
                                  input logic [15:0] limit);
    int unsigned start;
    write_limit(limit);
    gap_pct   = gap;
    stall_pct = stall;
    start     = sent_bytes;
    while (sent_bytes - start < ITEMS_PER_PHASE) begin
      if ($urandom_range(9) == 0) send_noise();
      else send_random_string();
    end
    cut_source();
    settle();
  endtask

  initial begin
    int unsigned gap_mix [4]   = '{0, 50, 0, 33};
    int unsigned stall_mix [4] = '{0, 0, 50, 33};
    logic [15:0] limits [4]    = '{16'hFFFF, 16'd12, 16'd40, 16'd7};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // waiting for the opening quote
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_QUOTE, 1'b1);
    // well-formed strings under the reset limit
    send_text("\"\"");
    send_text("\" Az~\"");
    send_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
    send_text("\"\\u0000\\u0041\\u00e9\\u07FF\\u20AC\\uFFFF\"");
    send_text("\"\\uD83D\\uDE00\\uDBFF\\uDFFF\\ud800\\udc00\"");
    send_text("\"\303\251\342\202\254\360\237\230\200\"");
    // utf-8 faults show up only at the closing quote
    send_text("\"\377\"");
    send_text("\"\303\"");
    send_text("\"\300\200\"");
    send_text("\"\355\240\200\"");
    send_text("\"\364\220\200\200\"");
    // control bytes, bad escapes, bad hex, surrogate misuse, early end
    send_text("\"a\037");
    send_text("\"");
    send_item(8'h00, 1'b0);
    send_text("\"\\x");
    send_text("\"\\");
    cut_source();
    send_text("\"\\u12G4");
    send_text("\"\\u1");
    cut_source();
    send_text("\"\\uD800\\uDC0z");
    send_text("\"\\uDC00");
    send_text("\"\\uD800a");
    send_text("\"\\uD800\\n");
    send_text("\"\\uD800\\u0041");
    send_text("\"\\uD800");
    cut_source();
    send_text("\"\\uD800\\");
    cut_source();
    send_text("\"ab");
    cut_source();
    settle();

    // length limit
    write_limit(16'd0);
    send_text("\"\"");
    send_text("\"a");
    settle();
    write_limit(16'd3);
    send_text("\"\\u20AC\"");
    send_text("\"a\\u00e9b");
    send_text("\"ab\\u20AC");
    send_text("\"\\uD83D\\uDE00");
    settle();
    // limit lowered while a string is open, caught at the closing quote
    write_limit(16'hFFFF);
    send_text("\"abcd");
    settle();
    write_limit(16'd2);
    send_text("\"");
    settle();

    for (int p = 0; p < 4; p++) run_random_phase(gap_mix[p], stall_mix[p], limits[p]);

    stall_pct = 0;
    settle();
    repeat (8) @(posedge clk);
    chk.summarize(sent_bytes);
    if (chk.mismatches == 0 && chk.drained())
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/jsu_pkg.sv
rtl/json_string_unescape_validate_core.sv
test/jsu_tb_pkg.sv
test/json_string_unescape_validate_core_tb.sv
